FILE: rtl/sbb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sbb_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_RADIUS = 15;
    localparam int RING       = 2 * MAX_RADIUS + 1;
    localparam int RING_W     = $clog2(RING);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int DIM_W      = 13;
    localparam int RAD_W      = 4;
    localparam int SUM_W      = 13;
    localparam int CNT_W      = 5;
    localparam int HS_DEPTH   = RING * MAX_WIDTH;
    localparam int HS_AW      = RING_W + COL_W;
    localparam int PIX_W      = 24;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef struct packed {
        logic             clr;
        logic             acc;
        logic             start;
        logic [CNT_W-1:0] divisor;
    } t_lane_ctl;

endpackage
`default_nettype wire

FILE: rtl/sbb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module sbb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

FILE: rtl/sbb_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module sbb_lane (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sbb_pkg::t_lane_ctl i_ctl,
    input  wire logic [7:0]        i_data,
    output logic      [7:0]        o_mean,
    output logic                   o_done
);
    import sbb_pkg::*;

    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] r_quo;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_div;
    logic [3:0]       r_steps;
    logic             r_busy;
    logic [CNT_W:0]   trial;
    logic             fits;

    assign trial  = {r_rem, r_quo[SUM_W-1]};
    assign fits   = trial >= {1'b0, r_div};
    assign o_mean = r_quo[7:0];

    // Running sum of the window, then a restoring divide, one bit a cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            o_done  <= 1'b0;
            r_steps <= '0;
        end else if (i_ctl.start) begin
            r_busy  <= 1'b1;
            o_done  <= 1'b0;
            r_steps <= 4'(SUM_W);
        end else if (r_busy) begin
            r_steps <= r_steps - 4'd1;
            if (r_steps == 4'd1) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_sum <= '0;
        end else if (i_ctl.acc) begin
            r_sum <= r_sum + {{(SUM_W-8){1'b0}}, i_data};
        end
        if (i_ctl.start) begin
            r_quo <= r_sum;
            r_rem <= '0;
            r_div <= i_ctl.divisor;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= CNT_W'(trial - {1'b0, r_div});
                r_quo <= {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[CNT_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/separable_box_blur_rgb.sv
`timescale 1ns / 1ps
`default_nettype none
// Each position runs the passes that it needs (horizontal, vertical), each over
// the clipped window length.
// Throughput: one transaction at a time; the next is taken in the cycle after the last
// is done, and a result that waits on the receiver holds the block until it leaves.
// The pace is set by the window RAM reads (one a cycle) and the bit-serial divide.
// Reset (synchronous, active low) restores radius 1, 640 by 480 and frame start.
module separable_box_blur_rgb (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // in_chan0, in_chan1, in_chan2
    input  wire logic        s_tuser,   // operation (pad flag)
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // out_chan0, out_chan1, out_chan2
    output logic             m_tlast,   // frame_last
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [12:0] i_cfg_data
);
    import sbb_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PIX    = 3'd1;
    localparam logic [2:0] S_SETUP  = 3'd2;
    localparam logic [2:0] S_RD     = 3'd3;
    localparam logic [2:0] S_LAST   = 3'd4;
    localparam logic [2:0] S_DSTART = 3'd5;
    localparam logic [2:0] S_DWAIT  = 3'd6;
    localparam logic [2:0] S_FIN    = 3'd7;

    // Configuration registers.
    logic [RAD_W-1:0] r_radius;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;

    // Raster position in the extended frame, with the ring positions kept alongside.
    logic [DIM_W-1:0]  r_cx, r_cy;
    logic [RING_W-1:0] r_cmod, r_rmod;

    // The transaction being worked on.
    logic [PIX_W-1:0]  r_pix;
    logic              r_wr_pix, r_do_h, r_do_v, r_last;
    logic [COL_W-1:0]  r_ox;
    logic [RING_W-1:0] r_pcmod, r_prmod;
    logic [RING_W-1:0] r_hstart, r_vstart;
    logic [CNT_W-1:0]  r_hcnt, r_vcnt;

    logic [2:0]        r_state;
    logic              r_pass;
    logic [CNT_W-1:0]  r_k;
    logic [RING_W-1:0] r_addr;
    logic              r_rdv;

    logic              r_ovalid;
    logic [PIX_W-1:0]  r_odata;
    logic              r_olast;

    // Effective frame size and radius, clipped to what the stores hold.
    logic [DIM_W-1:0] w, h, rr;

    always_comb begin
        if (r_width == '0) begin
            w = DIM_W'(1);
        end else if (r_width > DIM_W'(MAX_WIDTH)) begin
            w = DIM_W'(MAX_WIDTH);
        end else begin
            w = r_width;
        end
        if (r_height == '0) begin
            h = DIM_W'(1);
        end else if (r_height > DIM_W'(MAX_HEIGHT)) begin
            h = DIM_W'(MAX_HEIGHT);
        end else begin
            h = r_height;
        end
        rr = {{(DIM_W-RAD_W){1'b0}}, r_radius};
        if (rr > DIM_W'(MAX_RADIUS)) rr = DIM_W'(MAX_RADIUS);
        if (rr > w - DIM_W'(1)) rr = w - DIM_W'(1);
        if (rr > h - DIM_W'(1)) rr = h - DIM_W'(1);
    end

    // Window bounds for the incoming position, worked out as it is accepted.
    logic [DIM_W-1:0]  ox, oy, lo_h, hi_h, lo_v, hi_v;
    logic [CNT_W-1:0]  d_h, d_v;
    logic [RING_W:0]   hstart_w, vstart_w;
    logic              do_h, do_v, wr_pix;

    always_comb begin
        ox     = r_cx - rr;
        oy     = r_cy - rr;
        wr_pix = (r_cy < h) && (r_cx < w);
        do_h   = (r_cy < h) && (r_cx >= rr) && (ox < w);
        do_v   = (r_cx >= rr) && (r_cy >= rr) && (ox < w) && (oy < h);
        lo_h   = (ox >= rr) ? ox - rr : '0;
        hi_h   = (ox + rr < w) ? ox + rr : w - DIM_W'(1);
        lo_v   = (oy >= rr) ? oy - rr : '0;
        hi_v   = (oy + rr < h) ? oy + rr : h - DIM_W'(1);
        d_h    = CNT_W'(r_cx - lo_h);
        d_v    = CNT_W'(r_cy - lo_v);
        // Ring position of the window start: step back from the current position.
        if ({1'b0, r_cmod} >= {1'b0, d_h}) begin
            hstart_w = {1'b0, r_cmod} - {1'b0, d_h};
        end else begin
            hstart_w = {1'b0, r_cmod} + (RING_W+1)'(RING) - {1'b0, d_h};
        end
        if ({1'b0, r_rmod} >= {1'b0, d_v}) begin
            vstart_w = {1'b0, r_rmod} - {1'b0, d_v};
        end else begin
            vstart_w = {1'b0, r_rmod} + (RING_W+1)'(RING) - {1'b0, d_v};
        end
    end

    logic s_acc, out_free;
    assign s_tready = (r_state == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !r_ovalid || m_tready;

    // Stores: the row ring of pixels and the ring of horizontal means.
    logic [PIX_W-1:0] win_q, hs_q, merged;
    logic             rd_en;
    assign rd_en = (r_state == S_RD);

    sbb_ram #(.WIDTH(PIX_W), .DEPTH(RING)) u_win (
        .i_clk   (i_clk),
        .i_we    (r_state == S_PIX && r_wr_pix),
        .i_waddr (r_pcmod),
        .i_wdata (r_pix),
        .i_re    (rd_en && !r_pass),
        .i_raddr (r_addr),
        .o_rdata (win_q)
    );

    sbb_ram #(.WIDTH(PIX_W), .DEPTH(HS_DEPTH)) u_hstore (
        .i_clk   (i_clk),
        .i_we    (r_state == S_FIN && !r_pass),
        .i_waddr ({r_prmod, r_ox}),
        .i_wdata (merged),
        .i_re    (rd_en && r_pass),
        .i_raddr ({r_addr, r_ox}),
        .o_rdata (hs_q)
    );

    // Three colour lanes run side by side; their means are merged into one word.
    t_lane_ctl       lane_ctl;
    logic [PIX_W-1:0] lane_in;
    logic [2:0]       lane_done;
    logic [7:0]       lane_mean [3];

    assign lane_ctl.clr     = (r_state == S_SETUP);
    assign lane_ctl.acc     = r_rdv;
    assign lane_ctl.start   = (r_state == S_DSTART);
    assign lane_ctl.divisor = r_pass ? r_vcnt : r_hcnt;
    assign lane_in          = r_pass ? hs_q : win_q;
    assign merged           = {lane_mean[2], lane_mean[1], lane_mean[0]};

    for (genvar g = 0; g < 3; g++) begin : g_lane
        sbb_lane u_lane (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (lane_ctl),
            .i_data (lane_in[8*g +: 8]),
            .o_mean (lane_mean[g]),
            .o_done (lane_done[g])
        );
    end

    // Control: configuration, raster counters, sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RAD_W'(1);
            r_width  <= DIM_W'(640);
            r_height <= DIM_W'(480);
            r_cx     <= '0;
            r_cy     <= '0;
            r_cmod   <= '0;
            r_rmod   <= '0;
            r_state  <= S_IDLE;
            r_pass   <= 1'b0;
            r_rdv    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_rdv <= rd_en;
            // A finished vertical pass loads the output register once it is free.
            if (r_state == S_FIN && r_pass && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we && (i_cfg_idx inside {REG_RADIUS, REG_WIDTH, REG_HEIGHT})) begin
                case (i_cfg_idx)
                    REG_RADIUS: r_radius <= i_cfg_data[RAD_W-1:0];
                    REG_WIDTH:  r_width  <= i_cfg_data;
                    REG_HEIGHT: r_height <= i_cfg_data;
                    default:    r_radius <= r_radius;
                endcase
                r_cx   <= '0;
                r_cy   <= '0;
                r_cmod <= '0;
                r_rmod <= '0;
            end else if (s_acc) begin
                if (r_cx + DIM_W'(1) >= w + rr) begin
                    r_cx   <= '0;
                    r_cmod <= '0;
                    if (r_cy + DIM_W'(1) >= h + rr) begin
                        r_cy   <= '0;
                        r_rmod <= '0;
                    end else begin
                        r_cy   <= r_cy + DIM_W'(1);
                        r_rmod <= (r_rmod == RING_W'(RING - 1)) ? '0 : r_rmod + RING_W'(1);
                    end
                end else begin
                    r_cx   <= r_cx + DIM_W'(1);
                    r_cmod <= (r_cmod == RING_W'(RING - 1)) ? '0 : r_cmod + RING_W'(1);
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (s_acc) r_state <= S_PIX;
                end
                S_PIX: begin
                    if (r_do_h) begin
                        r_pass  <= 1'b0;
                        r_state <= S_SETUP;
                    end else if (r_do_v) begin
                        r_pass  <= 1'b1;
                        r_state <= S_SETUP;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_SETUP: begin
                    r_k     <= '0;
                    r_addr  <= r_pass ? r_vstart : r_hstart;
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_k    <= r_k + CNT_W'(1);
                    r_addr <= (r_addr == RING_W'(RING - 1)) ? '0 : r_addr + RING_W'(1);
                    if (r_k == (r_pass ? r_vcnt : r_hcnt) - CNT_W'(1)) begin
                        r_state <= S_LAST;
                    end
                end
                S_LAST:   r_state <= S_DSTART;
                S_DSTART: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (&lane_done) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_pass) begin
                        if (r_do_v) begin
                            r_pass  <= 1'b1;
                            r_state <= S_SETUP;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_pix    <= s_tdata;
            r_wr_pix <= wr_pix;
            r_do_h   <= do_h;
            r_do_v   <= do_v;
            r_ox     <= ox[COL_W-1:0];
            r_pcmod  <= r_cmod;
            r_prmod  <= r_rmod;
            r_hstart <= hstart_w[RING_W-1:0];
            r_vstart <= vstart_w[RING_W-1:0];
            r_hcnt   <= CNT_W'(hi_h - lo_h + DIM_W'(1));
            r_vcnt   <= CNT_W'(hi_v - lo_v + DIM_W'(1));
            r_last   <= (ox == w - DIM_W'(1)) && (oy == h - DIM_W'(1));
        end
        if (r_state == S_FIN && r_pass && out_free) begin
            r_odata <= merged;
            r_olast <= r_last;
        end
    end

    assign m_tvalid = r_ovalid;
    assign m_tdata  = r_odata;
    assign m_tlast  = r_olast;

    logic unused_user;
    assign unused_user = s_tuser;
endmodule
`default_nettype wire

FILE: rtl/sbb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module sbb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast
);
    // A stalled result holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // After an accepted transaction the block takes no input in the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on consecutive cycles");

    // Reset leaves no result pending.
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // A new result appears only while the block is not taking input.
    a_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised from idle");
endmodule

bind separable_box_blur_rgb sbb_checker u_sbb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);
`default_nettype wire

FILE: tb/separable_box_blur_rgb_checker.sv
`timescale 1ns / 1ps
module separable_box_blur_rgb_checker
    import sbb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct packed {
        logic        last;
        logic [23:0] pix;
    } blur_t;

    logic [RAD_W-1:0] radius_q;
    logic [DIM_W-1:0] width_q, height_q;
    int               col, row;
    logic [23:0]      row_ring [RING];
    logic [23:0]      hmean [RING][MAX_WIDTH];
    blur_t            blur_q[$];

    assign o_pending = blur_q.size();

    function automatic int clamp_dim(input int v, input int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    task automatic blur_pixel(input logic [23:0] pix);
        int    w, h, r, lo, hi, cnt, ox, oy;
        int    s [3];
        blur_t res;
        w = clamp_dim(width_q, MAX_WIDTH);
        h = clamp_dim(height_q, MAX_HEIGHT);
        r = radius_q;
        if (r > w - 1) r = w - 1;
        if (r > h - 1) r = h - 1;
        if (row < h && col < w) row_ring[col % RING] = pix;
        if (row < h && col >= r && col - r < w) begin
            ox = col - r;
            lo = (ox >= r) ? ox - r : 0;
            hi = (ox + r < w) ? ox + r : w - 1;
            cnt = hi - lo + 1;
            s = '{0, 0, 0};
            for (int i = lo; i <= hi; i++)
                for (int k = 0; k < 3; k++) s[k] += row_ring[i % RING][8*k +: 8];
            for (int k = 0; k < 3; k++) hmean[row % RING][ox][8*k +: 8] = 8'(s[k] / cnt);
        end
        if (col >= r && row >= r && col - r < w && row - r < h) begin
            ox = col - r;
            oy = row - r;
            lo = (oy >= r) ? oy - r : 0;
            hi = (oy + r < h) ? oy + r : h - 1;
            cnt = hi - lo + 1;
            s = '{0, 0, 0};
            for (int j = lo; j <= hi; j++)
                for (int k = 0; k < 3; k++) s[k] += hmean[j % RING][ox][8*k +: 8];
            for (int k = 0; k < 3; k++) res.pix[8*k +: 8] = 8'(s[k] / cnt);
            res.last = (ox == w - 1 && oy == h - 1);
            blur_q.push_back(res);
        end
        col++;
        if (col >= w + r) begin
            col = 0;
            row++;
            if (row >= h + r) row = 0;
        end
    endtask

    always @(posedge i_clk) begin
        blur_t exp_res;
        if (!i_rst_n) begin
            radius_q <= 4'd1;
            width_q  <= 13'd640;
            height_q <= 13'd480;
            col = 0;
            row = 0;
            o_fail_count <= 0;
            blur_q.delete();
        end else begin
            if (i_cfg_we && (i_cfg_idx inside {REG_RADIUS, REG_WIDTH, REG_HEIGHT})) begin
                case (i_cfg_idx)
                    REG_RADIUS: radius_q <= i_cfg_data[RAD_W-1:0];
                    REG_WIDTH:  width_q  <= i_cfg_data;
                    REG_HEIGHT: height_q <= i_cfg_data;
                    default: ;
                endcase
                col = 0;
                row = 0;
            end
            if (s_tvalid && s_tready) blur_pixel(s_tdata);
            if (m_tvalid && m_tready) begin
                if (blur_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("Unexpected result %h last %b", m_tdata, m_tlast);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_res = blur_q.pop_front();
                    if (exp_res.pix !== m_tdata || exp_res.last !== m_tlast) begin
                        if (o_fail_count < 10)
                            $display("Mismatch: expected %h last %b, got %h last %b",
                                     exp_res.pix, exp_res.last, m_tdata, m_tlast);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: tb/separable_box_blur_rgb_test.sv
`timescale 1ns / 1ps
module separable_box_blur_rgb_test;
    import sbb_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = REG_RADIUS;
    logic [12:0] i_cfg_data = '0;
    int          fail_count, pending;
    int          idle_cycles = 0;
    bit          hold_off = 1'b0;
    bit          sink_on = 1'b0;

    always #10 i_clk = ~i_clk;

    separable_box_blur_rgb dut (.*);

    separable_box_blur_rgb_checker checker_i (
        .i_clk, .i_rst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
        .m_tdata, .m_tlast, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Mostly short gaps, now and then a long one, and runs with none at all.
    function automatic int gap_len();
        int d;
        d = $urandom_range(0, 99);
        if (d < 55) return 0;
        if (d < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, plus a long hold-off on request from the stimulus.
    always @(negedge i_clk) begin
        if (!sink_on || hold_off) m_tready <= 1'b0;
        else m_tready <= (gap_len() == 0);
    end

    // Watchdog: any cycle without a transaction on either side counts towards the limit.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input int value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[12:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Let the block drain fully; positions with no result may still be in flight.
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    task automatic send_pixel(input logic [23:0] pix, input logic pad);
        int g;
        g = gap_len();
        @(negedge i_clk);
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= pad;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_pix(input int style);
        case (style)
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return $urandom();
        endcase
    endfunction

    // One whole extended frame of (w+r) by (h+r) positions, padding marked in tuser.
    task automatic send_frame(input int w, input int h, input int r, input int style);
        int re;
        re = r;
        if (re > w - 1) re = w - 1;
        if (re > h - 1) re = h - 1;
        for (int y = 0; y < h + re; y++)
            for (int x = 0; x < w + re; x++)
                send_pixel(rand_pix(style), (x >= w || y >= h));
        @(negedge i_clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic configure(input int r, input int w, input int h);
        write_reg(REG_RADIUS, r);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    initial begin
        int sent;
        int w, h, r;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        sink_on <= 1'b1;

        // Directed part: smallest frame, saturated radius, all-ones samples.
        configure(0, 1, 1);
        send_frame(1, 1, 0, 1);
        drain();
        configure(15, 2, 2);
        send_frame(2, 2, 15, 1);
        drain();
        // Zero sizes count as one; an unknown register index must change nothing.
        configure(3, 0, 0);
        write_reg(2'd3, 13'h1FFF);
        send_frame(1, 1, 3, 2);
        drain();
        // Oversized width and height saturate; only a partial frame is sent.
        configure(2, 8191, 8191);
        for (int i = 0; i < 12; i++) send_pixel(rand_pix(i % 3), 1'b0);
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        drain();
        // Pad samples and the pad flag are ignored: drive the flag on every other sample.
        configure(1, 3, 2);
        for (int i = 0; i < 12; i++) send_pixel(rand_pix(2), (i % 2) == 0);
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        drain();

        // Long receiver hold-off while the sender keeps offering items.
        configure(4, 9, 5);
        fork
            send_frame(9, 5, 4, 2);
            begin
                hold_off = 1'b1;
                repeat (400) @(negedge i_clk);
                hold_off = 1'b0;
            end
        join
        drain();

        // Random frames, mostly small, now and then one with the full radius and a wide row.
        sent = 0;
        while (sent < 1650) begin
            if ($urandom_range(0, 9) == 0) begin
                r = 15;
                w = $urandom_range(31, 40);
                h = $urandom_range(16, 20);
            end else begin
                r = $urandom_range(0, 5);
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 10);
            end
            configure(r, w, h);
            send_frame(w, h, r, $urandom_range(0, 7));
            if (r > w - 1) r = w - 1;
            if (r > h - 1) r = h - 1;
            sent += (w + r) * (h + r);
            // Sometimes a second frame runs on without a register write.
            if ($urandom_range(0, 3) == 0) begin
                send_frame(w, h, r, 2);
                sent += (w + r) * (h + r);
            end
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
